// ===== rtl/core/dtts_pkg.sv =====
// Shared types, character codes, status codes and parse-step functions for the
// duration text to seconds block. Depends on nothing; used by every module in rtl/core.
package dtts_pkg;

    localparam int CNT_W = 20;
    localparam int TOT_W = 51;
    localparam int SEC_W = 25;

    localparam logic [CNT_W-1:0] CNT_MAX = 20'd999999;

    localparam logic [SEC_W-1:0] SEC_MINUTE = 25'd60;
    localparam logic [SEC_W-1:0] SEC_HOUR   = 25'd3600;
    localparam logic [SEC_W-1:0] SEC_DAY    = 25'd86400;
    localparam logic [SEC_W-1:0] SEC_MONTH  = 25'd2592000;
    localparam logic [SEC_W-1:0] SEC_YEAR   = 25'd31536000;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Y     = 8'h59;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_PREFIX = 3'd1;
    localparam logic [2:0] ST_COLON  = 3'd2;
    localparam logic [2:0] ST_CHAR   = 3'd3;
    localparam logic [2:0] ST_LONG   = 3'd4;

    typedef enum logic [15:0] {
        PH_START    = 16'h0001,
        PH_WANT_P   = 16'h0002,
        PH_AFTER_P  = 16'h0004,
        PH_LA_A     = 16'h0008,
        PH_LA_B     = 16'h0010,
        PH_LA_C     = 16'h0020,
        PH_D_START  = 16'h0040,
        PH_D_DIGITS = 16'h0080,
        PH_H1       = 16'h0100,
        PH_H2       = 16'h0200,
        PH_C1       = 16'h0400,
        PH_M1       = 16'h0800,
        PH_M2       = 16'h1000,
        PH_C2       = 16'h2000,
        PH_SEC      = 16'h4000,
        PH_SINK     = 16'h8000
    } phase_t;

    // Parse state that one character step updates.
    typedef struct packed {
        phase_t           phase;
        logic [2:0]       err;
        logic [CNT_W-1:0] acc;
        logic [CNT_W-1:0] yr;
        logic [CNT_W-1:0] mo;
        logic [CNT_W-1:0] dy;
        logic [CNT_W-1:0] hr;
        logic [CNT_W-1:0] mi;
        logic [CNT_W-1:0] se;
    } prs_t;

    // Finished text handed from the parser to the arithmetic pipeline.
    typedef struct packed {
        logic             neg;
        logic [2:0]       err;
        logic [CNT_W-1:0] yr;
        logic [CNT_W-1:0] mo;
        logic [CNT_W-1:0] dy;
        logic [CNT_W-1:0] hr;
        logic [CNT_W-1:0] mi;
        logic [CNT_W-1:0] se;
    } snap_t;

    localparam prs_t PRS_RESET = '{
        phase: PH_START, err: ST_OK, acc: '0, yr: '0, mo: '0,
        dy: '0, hr: '0, mi: '0, se: '0
    };

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    // acc * 10 + digit, saturated.
    function automatic logic [CNT_W-1:0] push_digit(logic [CNT_W-1:0] acc, logic [7:0] c);
        logic [CNT_W+4:0] v;
        v = ({5'd0, acc} << 3) + ({5'd0, acc} << 1) + {21'd0, c[3:0]};
        return (v > {5'd0, CNT_MAX}) ? CNT_MAX : v[CNT_W-1:0];
    endfunction

    // Keep the first error, except that too long always wins and colon missing
    // replaces an unrecognized character. Fatal errors park the parser.
    function automatic prs_t raise_error(prs_t s, logic [2:0] code);
        prs_t r;
        r = s;
        if (code == ST_LONG || s.err == ST_OK || (code == ST_COLON && s.err == ST_CHAR))
            r.err = code;
        if (code == ST_PREFIX || code == ST_COLON || code == ST_LONG)
            r.phase = PH_SINK;
        return r;
    endfunction

    // One character of the date or time part.
    function automatic prs_t feed(prs_t s, logic [7:0] c);
        prs_t r;
        r = s;
        unique case (s.phase)
            PH_D_START, PH_D_DIGITS:
            begin
                if (is_digit(c))
                begin
                    r.acc   = push_digit(s.acc, c);
                    r.phase = PH_D_DIGITS;
                end
                else if (c == CH_Y || c == CH_M || c == CH_D)
                begin
                    if (c == CH_Y)
                        r.yr = s.acc;
                    else if (c == CH_M)
                        r.mo = s.acc;
                    else
                        r.dy = s.acc;
                    r.acc   = '0;
                    r.phase = PH_D_START;
                end
                else if (c == CH_T)
                begin
                    if (s.phase == PH_D_DIGITS)
                        r = raise_error(r, ST_CHAR);
                    r.acc   = '0;
                    r.phase = PH_H1;
                end
                else
                begin
                    r       = raise_error(r, ST_CHAR);
                    r.acc   = '0;
                    r.phase = PH_D_START;
                end
            end
            PH_H1, PH_H2:
            begin
                if (is_digit(c))
                    r.hr = push_digit(s.hr, c);
                else
                    r = raise_error(r, ST_CHAR);
                r.phase = (s.phase == PH_H1) ? PH_H2 : PH_C1;
            end
            PH_M1, PH_M2:
            begin
                if (is_digit(c))
                    r.mi = push_digit(s.mi, c);
                else
                    r = raise_error(r, ST_CHAR);
                r.phase = (s.phase == PH_M1) ? PH_M2 : PH_C2;
            end
            PH_C1, PH_C2:
            begin
                if (c == CH_COLON)
                    r.phase = (s.phase == PH_C1) ? PH_M1 : PH_SEC;
                else
                    r = raise_error(r, ST_COLON);
            end
            PH_SEC:
            begin
                if (is_digit(c))
                    r.se = push_digit(s.se, c);
                else
                    r = raise_error(r, ST_CHAR);
            end
            default:
            begin
                r = s;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/duration_text_to_seconds.sv =====
// Duration text to seconds, top level: parser plus seconds pipeline.
// Depends on dtts_pkg, dtts_parser and dtts_total.
// Throughput: one character per cycle while in_stall is low.
// The result reaches out_valid through the hand-off register, then the scaling,
// pair sum and final sum registers.
// Reset: rst_n clears the parse state and all pipeline valid flags at once.
module duration_text_to_seconds
    import dtts_pkg::*;
#(
    parameter int MAX_CHARS = 128
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       char_code,
    input  logic             last_char,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       status,
    output logic [TOT_W-1:0] total_seconds
);

    // Finished text travels from the parser to the arithmetic as one struct.
    snap_t snap;
    logic  snap_valid;
    logic  snap_take;

    // Parser: takes an item every cycle unless a finished text is still
    // waiting in its hand-off register and the pipeline cannot take it.
    // It tracks the sign, the two-character lookahead after "PT", the
    // per-unit counts, the error priority and the length limit.
    dtts_parser #(
        .MAX_CHARS (MAX_CHARS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .last_char  (last_char),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_take  (snap_take)
    );

    // Seconds pipeline: scale each count by its unit, add in pairs with the
    // sign applied, then add the three pairs into the output register. Each
    // stage moves on as soon as the one after it has room, so a stalled
    // result does not hold up the parser until all stages are full.
    dtts_total u_total (
        .clk           (clk),
        .rst_n         (rst_n),
        .snap_valid    (snap_valid),
        .snap          (snap),
        .snap_take     (snap_take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .total_seconds (total_seconds)
    );

endmodule

// ===== rtl/core/dtts_parser.sv =====
// Character parser: one text character per cycle while not stalled, holds the
// parse state and hands a finished text to the next stage. Depends on dtts_pkg.
module dtts_parser
    import dtts_pkg::*;
#(
    parameter int MAX_CHARS = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       snap_valid,
    output snap_t      snap,
    input  logic       snap_take
);

    localparam int CW = $clog2(MAX_CHARS + 1);

    prs_t          prs_reg, prs_next;
    logic          neg_reg, neg_next;
    logic [7:0]    la0_reg, la0_next;
    logic [7:0]    la1_reg, la1_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          snap_valid_reg, snap_valid_next;
    snap_t         snap_reg, snap_next;
    logic          accept;

    // Hold input only while a finished text waits in the hand-off register.
    assign in_stall   = snap_valid_reg && !snap_take;
    assign accept     = in_valid && !in_stall;
    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    always_comb
    begin : step_logic
        prs_t          s;
        logic          n;
        logic [7:0]    l0;
        logic [7:0]    l1;
        logic [CW-1:0] cnt_inc;

        s       = prs_reg;
        n       = neg_reg;
        l0      = la0_reg;
        l1      = la1_reg;
        cnt_inc = (cnt_reg < CW'(MAX_CHARS)) ? cnt_reg + CW'(1) : cnt_reg;

        if (cnt_inc >= CW'(MAX_CHARS))
            s = raise_error(s, ST_LONG);

        unique case (s.phase)
            PH_START:
            begin
                if (char_code == CH_MINUS)
                begin
                    n       = 1'b1;
                    s.phase = PH_WANT_P;
                end
                else if (char_code == CH_P)
                    s.phase = PH_AFTER_P;
                else
                    s = raise_error(s, ST_PREFIX);
            end
            PH_WANT_P:
            begin
                if (char_code == CH_P)
                    s.phase = PH_AFTER_P;
                else
                    s = raise_error(s, ST_PREFIX);
            end
            PH_AFTER_P:
            begin
                if (char_code == CH_T)
                    s.phase = last_char ? PH_D_START : PH_LA_A;
                else
                begin
                    s.phase = PH_D_START;
                    s       = feed(s, char_code);
                end
            end
            PH_LA_A:
            begin
                if (last_char)
                begin
                    s.phase = PH_D_START;
                    s       = feed(s, char_code);
                end
                else
                begin
                    l0      = char_code;
                    s.phase = PH_LA_B;
                end
            end
            PH_LA_B:
            begin
                if (last_char)
                begin
                    s.phase = PH_D_START;
                    s       = feed(s, la0_reg);
                    s       = feed(s, char_code);
                end
                else
                begin
                    l1      = char_code;
                    s.phase = PH_LA_C;
                end
            end
            PH_LA_C:
            begin
                // Colon third after the T: keep it as the time marker.
                s.phase = (char_code == CH_COLON) ? PH_H1 : PH_D_START;
                s       = feed(s, la0_reg);
                s       = feed(s, la1_reg);
                s       = feed(s, char_code);
            end
            PH_SINK:
            begin
                s = s;
            end
            default:
            begin
                s = feed(s, char_code);
            end
        endcase

        if (last_char)
        begin
            if (s.phase == PH_START || s.phase == PH_WANT_P)
                s = raise_error(s, ST_PREFIX);
            else if (s.phase == PH_D_DIGITS)
                s = raise_error(s, ST_CHAR);
            else if (s.phase == PH_H1 || s.phase == PH_H2 || s.phase == PH_C1 ||
                     s.phase == PH_M1 || s.phase == PH_M2 || s.phase == PH_C2)
                s = raise_error(s, ST_COLON);
        end

        snap_next = '{neg: n, err: s.err, yr: s.yr, mo: s.mo, dy: s.dy,
                      hr: s.hr, mi: s.mi, se: s.se};

        // Default: hold.
        prs_next        = prs_reg;
        neg_next        = neg_reg;
        la0_next        = la0_reg;
        la1_next        = la1_reg;
        cnt_next        = cnt_reg;
        snap_valid_next = snap_valid_reg && !snap_take;

        if (accept)
        begin
            if (last_char)
            begin
                // Drop all parse state so the next character opens a new text.
                prs_next        = PRS_RESET;
                neg_next        = 1'b0;
                la0_next        = '0;
                la1_next        = '0;
                cnt_next        = '0;
                snap_valid_next = 1'b1;
            end
            else
            begin
                prs_next = s;
                neg_next = n;
                la0_next = l0;
                la1_next = l1;
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prs_reg        <= PRS_RESET;
            neg_reg        <= 1'b0;
            la0_reg        <= '0;
            la1_reg        <= '0;
            cnt_reg        <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            prs_reg        <= prs_next;
            neg_reg        <= neg_next;
            la0_reg        <= la0_next;
            la1_reg        <= la1_next;
            cnt_reg        <= cnt_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_char)
            snap_reg <= snap_next;
    end

endmodule

// ===== rtl/core/dtts_total.sv =====
// Seconds pipeline: scales the unit counts, sums them, applies the sign and
// holds the result for the output channel. Depends on dtts_pkg.
module dtts_total
    import dtts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             snap_valid,
    input  snap_t            snap,
    output logic             snap_take,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       status,
    output logic [TOT_W-1:0] total_seconds
);

    // Stage B: scaled unit counts.
    logic             b_valid_reg, b_valid_next;
    logic             b_neg_reg;
    logic [2:0]       b_err_reg;
    logic [TOT_W-1:0] b_prod_reg [6];
    logic [TOT_W-1:0] b_prod_next [6];
    // Stage C: signed pair sums.
    logic             c_valid_reg, c_valid_next;
    logic [2:0]       c_err_reg;
    logic [TOT_W-1:0] c_pair_reg [3];
    logic [TOT_W-1:0] c_pair_next [3];
    // Stage D: output register.
    logic             d_valid_reg, d_valid_next;
    logic [2:0]       d_err_reg;
    logic [TOT_W-1:0] d_total_reg, d_total_next;

    logic b_ready, c_ready, d_ready;

    // Each stage fills when empty or when its contents move on.
    assign d_ready   = !d_valid_reg || !out_stall;
    assign c_ready   = !c_valid_reg || d_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign snap_take = b_ready;

    assign b_valid_next = b_ready ? snap_valid  : b_valid_reg;
    assign c_valid_next = c_ready ? b_valid_reg : c_valid_reg;
    assign d_valid_next = d_ready ? c_valid_reg : d_valid_reg;

    function automatic logic [TOT_W-1:0] scale(logic [CNT_W-1:0] n, logic [SEC_W-1:0] k);
        return TOT_W'({{SEC_W{1'b0}}, n} * {{CNT_W{1'b0}}, k});
    endfunction

    always_comb
    begin
        b_prod_next[0] = scale(snap.yr, SEC_YEAR);
        b_prod_next[1] = scale(snap.mo, SEC_MONTH);
        b_prod_next[2] = scale(snap.dy, SEC_DAY);
        b_prod_next[3] = scale(snap.hr, SEC_HOUR);
        b_prod_next[4] = scale(snap.mi, SEC_MINUTE);
        b_prod_next[5] = TOT_W'(snap.se);
        // Any error forces a zero total.
        if (snap.err != ST_OK)
        begin
            for (int i = 0; i < 6; i++)
                b_prod_next[i] = '0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_pair_next[i] = b_prod_reg[2*i] + b_prod_reg[2*i+1];
            if (b_neg_reg)
                c_pair_next[i] = TOT_W'(0) - c_pair_next[i];
        end
    end

    assign d_total_next = c_pair_reg[0] + c_pair_reg[1] + c_pair_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && snap_valid)
        begin
            b_neg_reg  <= snap.neg;
            b_err_reg  <= snap.err;
            b_prod_reg <= b_prod_next;
        end
        if (c_ready && b_valid_reg)
        begin
            c_err_reg  <= b_err_reg;
            c_pair_reg <= c_pair_next;
        end
        if (d_ready && c_valid_reg)
        begin
            d_err_reg   <= c_err_reg;
            d_total_reg <= d_total_next;
        end
    end

    assign out_valid     = d_valid_reg;
    assign status        = d_err_reg;
    assign total_seconds = d_total_reg;

endmodule
